/* hdl/mapg_pkg.sv */
// Package for the multi-axis PID with goal check.
// Holds widths, margins, the sequencer state type and saturation helpers.
// No dependencies.
package mapg_pkg;
	localparam int NUM_AXES   = 6;
	localparam int AXIS_W     = 3;
	localparam int DW         = 32;
	localparam int TOL_W      = 31;
	localparam logic [DW-1:0] MARGIN_XY  = 32'd9830;
	localparam logic [DW-1:0] MARGIN_Z   = 32'd13107;
	localparam logic [DW-1:0] MARGIN_YAW = 32'd6554;
	localparam logic [AXIS_W-1:0] LAST_AXIS = AXIS_W'(NUM_AXES - 1);
	localparam logic [0:0] REG_TOL  = 1'b0;
	localparam logic [0:0] REG_AUTO = 1'b1;
	localparam int DIV_STEPS = 49;

	typedef enum logic [3:0] {
		ST_IDLE, ST_READ, ST_INTEG, ST_WRINT, ST_DIV, ST_MULP, ST_MULI, ST_MULD,
		ST_OUT, ST_CLEAR
	} state_t;

	// saturate a 66-bit signed value to 32 bits
	function automatic logic signed [DW-1:0] sat32(input logic signed [65:0] v);
		logic signed [65:0] hi;
		logic signed [65:0] lo;
		begin
			hi = 66'sd2147483647;
			lo = -66'sd2147483648;
			if (v > hi) sat32 = 32'sh7fffffff;
			else if (v < lo) sat32 = 32'sh80000000;
			else sat32 = v[DW-1:0];
		end
	endfunction
endpackage

/* hdl/multi_axis_pid_with_goal_check.sv */
// Top level of the multi-axis PID with goal check.
// Depends on mapg_pkg; holds the state memories and the sequencer.
//
//  channel | direction | handshake          | payload
//  in      | sink      | in_valid/in_stall   | kind axis desired measured step gains
//  out     | source    | out_valid/out_stall | axis_out drive at_goal last
//  cfg     | sink      | cfg_we              | cfg_index cfg_data
//
// From its input transfer to out_valid a sample passes through one memory
// read, integral update, divide setup, a 49-step restoring divide of the
// error delta by time_step, signing and saturating of the rate,
// three passes of the shared 32x32 multiplier, then the result register.
// A goal with auto reset runs a clearing sweep. Reset clears control
// state and the valid bits of the stores; an entry whose valid bit is low
// reads as zero. in_stall is high while busy or while the output register
// is full.
module multi_axis_pid_with_goal_check (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic kind,
	input  logic [2:0] axis,
	input  logic signed [31:0] desired_value,
	input  logic signed [31:0] measured_value,
	input  logic [15:0] time_step,
	input  logic signed [31:0] gain_prop,
	input  logic signed [31:0] gain_integ,
	input  logic signed [31:0] gain_deriv,
	output logic out_valid,
	input  logic out_stall,
	output logic [2:0] axis_out,
	output logic signed [31:0] drive,
	output logic at_goal,
	output logic last,
	input  logic cfg_we,
	input  logic [0:0] cfg_index,
	input  logic [30:0] cfg_data
);
	localparam int AW = mapg_pkg::AXIS_W;
	localparam int DW = mapg_pkg::DW;

	// memories: gains in one, integral and previous error in another
	logic [3*DW-1:0] gain_mem [mapg_pkg::NUM_AXES];
	logic [2*DW-1:0] st_mem [mapg_pkg::NUM_AXES];
	logic [mapg_pkg::NUM_AXES-1:0] gain_vld_q, st_vld_q;
	logic [3*DW-1:0] gain_rd_q;
	logic [2*DW-1:0] st_rd_q;
	logic gain_rv_q, st_rv_q;

	mapg_pkg::state_t state_q, state_d;
	localparam int TOL_W_L = mapg_pkg::TOL_W;
	logic [TOL_W_L-1:0] tol_q;
	logic auto_q, goal_so_far_q;

	logic [AW-1:0] ax_q;
	logic signed [DW-1:0] e_q, integ_q, prev_q, rate_q;
	logic signed [32:0] diff_q;
	logic [15:0] dt_q;
	logic signed [65:0] acc_q;
	logic [5:0] cnt_q;
	logic [48:0] dnum_q;
	logic [48:0] quo_q;
	logic [16:0] rem_q;
	logic dneg_q;
	logic [AW-1:0] clr_q;
	logic signed [DW-1:0] ma_q, mb_q;
	logic signed [63:0] prod;
	logic signed [DW-1:0] kp, ki, kd, ist, pst;

	logic in_acc, out_acc, mem_we, clr_we;
	logic [2*DW-1:0] st_wdata;
	logic goal_now;

	assign in_acc  = in_valid && !in_stall;
	assign out_acc = out_valid && !out_stall;
	assign in_stall = (state_q != mapg_pkg::ST_IDLE) || out_valid;

	// read data with valid bits applied
	assign kp  = gain_rv_q ? gain_rd_q[3*DW-1:2*DW] : '0;
	assign ki  = gain_rv_q ? gain_rd_q[2*DW-1:DW] : '0;
	assign kd  = gain_rv_q ? gain_rd_q[DW-1:0] : '0;
	assign ist = st_rv_q ? st_rd_q[2*DW-1:DW] : '0;
	assign pst = st_rv_q ? st_rd_q[DW-1:0] : '0;

	assign prod = ma_q * mb_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			mapg_pkg::ST_IDLE:
				if (in_acc && axis < AW'(mapg_pkg::NUM_AXES) && !kind) state_d = mapg_pkg::ST_READ;
			mapg_pkg::ST_READ:  state_d = mapg_pkg::ST_INTEG;
			mapg_pkg::ST_INTEG: state_d = mapg_pkg::ST_WRINT;
			mapg_pkg::ST_WRINT: state_d = mapg_pkg::ST_DIV;
			mapg_pkg::ST_DIV:
				if (cnt_q == 6'(mapg_pkg::DIV_STEPS)) state_d = mapg_pkg::ST_MULP;
			mapg_pkg::ST_MULP:  state_d = mapg_pkg::ST_MULI;
			mapg_pkg::ST_MULI:  state_d = mapg_pkg::ST_MULD;
			mapg_pkg::ST_MULD:  state_d = mapg_pkg::ST_OUT;
			mapg_pkg::ST_OUT:
				state_d = (ax_q == mapg_pkg::LAST_AXIS && goal_now && auto_q) ?
					mapg_pkg::ST_CLEAR : mapg_pkg::ST_IDLE;
			mapg_pkg::ST_CLEAR:
				if (clr_q == mapg_pkg::LAST_AXIS) state_d = mapg_pkg::ST_IDLE;
			default: state_d = mapg_pkg::ST_IDLE;
		endcase
	end

	// goal check of this axis folded into the sweep flag
	logic [32:0] mag;
	logic [32:0] lim;
	logic chk;
	always_comb begin
		mag = diff_q[32] ? 33'(-diff_q) : 33'(diff_q);
		lim = 33'(tol_q);
		chk = 1'b0;
		case (ax_q)
			3'd0, 3'd1: begin lim = lim + 33'(mapg_pkg::MARGIN_XY); chk = 1'b1; end
			3'd2: begin lim = lim + 33'(mapg_pkg::MARGIN_Z); chk = 1'b1; end
			3'd5: begin lim = lim + 33'(mapg_pkg::MARGIN_YAW); chk = 1'b1; end
			default: chk = 1'b0;
		endcase
		goal_now = goal_so_far_q && !(chk && mag > lim);
	end

	// memory write control
	always_comb begin
		mem_we = (state_q == mapg_pkg::ST_OUT);
		clr_we = (state_q == mapg_pkg::ST_CLEAR);
		st_wdata = {integ_q, e_q};
	end

	// axis 2 integral kept across the clearing sweep
	logic [DW-1:0] z_keep_q;
	logic [DW-1:0] st_mem_z;
	assign st_mem_z = z_keep_q;

	// memories
	always_ff @(posedge clk) begin
		if (in_acc && kind && axis < AW'(mapg_pkg::NUM_AXES))
			gain_mem[axis] <= {gain_prop, gain_integ, gain_deriv};
		if (state_q == mapg_pkg::ST_IDLE) begin
			gain_rd_q <= gain_mem[axis];
			st_rd_q <= st_mem[axis];
		end
		if (mem_we)
			st_mem[ax_q] <= st_wdata;
		else if (clr_we)
			st_mem[clr_q] <= {(clr_q == 3'd2 && st_vld_q[2]) ? st_mem_z : '0, {DW{1'b0}}};
	end

	// control and datapath registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mapg_pkg::ST_IDLE;
			tol_q <= '0;
			auto_q <= 1'b0;
			goal_so_far_q <= 1'b1;
			gain_vld_q <= '0;
			st_vld_q <= '0;
			out_valid <= 1'b0;
			cnt_q <= '0;
			clr_q <= '0;
			gain_rv_q <= 1'b0;
			st_rv_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				if (cfg_index == mapg_pkg::REG_TOL) tol_q <= cfg_data;
				else auto_q <= cfg_data[0];
			end
			if (out_acc) out_valid <= 1'b0;
			if (in_acc && kind && axis < AW'(mapg_pkg::NUM_AXES)) gain_vld_q[axis] <= 1'b1;
			if (state_q == mapg_pkg::ST_IDLE) begin
				gain_rv_q <= gain_vld_q[axis];
				st_rv_q <= st_vld_q[axis];
			end
			if (state_q == mapg_pkg::ST_WRINT) cnt_q <= '0;
			else if (state_q == mapg_pkg::ST_DIV) cnt_q <= cnt_q + 6'd1;
			if (state_q == mapg_pkg::ST_OUT) begin
				out_valid <= 1'b1;
				st_vld_q[ax_q] <= 1'b1;
				goal_so_far_q <= (ax_q == mapg_pkg::LAST_AXIS) ? 1'b1 : goal_now;
				clr_q <= '0;
			end
			if (state_q == mapg_pkg::ST_CLEAR) clr_q <= clr_q + 3'd1;
		end
	end

	// payload path
	always_ff @(posedge clk) begin
		case (state_q)
			mapg_pkg::ST_IDLE: begin
				ax_q <= axis;
				diff_q <= 33'(desired_value) - 33'(measured_value);
				dt_q <= time_step;
			end
			mapg_pkg::ST_READ: begin
				e_q <= mapg_pkg::sat32(66'(diff_q));
				prev_q <= pst;
				integ_q <= ist;
				ma_q <= mapg_pkg::sat32(66'(diff_q));
				mb_q <= DW'(signed'({1'b0, dt_q}));
			end
			mapg_pkg::ST_INTEG:
				integ_q <= mapg_pkg::sat32(66'(integ_q) + 66'(prod >>> 16));
			mapg_pkg::ST_WRINT: begin
				acc_q <= 66'(prev_q) - 66'(e_q);
				dneg_q <= prev_q < e_q;
				dnum_q <= (prev_q < e_q) ? 49'(33'(e_q) - 33'(prev_q)) << 16
					: 49'(33'(prev_q) - 33'(e_q)) << 16;
				rem_q <= '0;
				quo_q <= '0;
			end
			mapg_pkg::ST_DIV: begin
				if (cnt_q < 6'(mapg_pkg::DIV_STEPS)) begin
					logic [17:0] t;
					logic [16:0] dv;
					dv = (dt_q == '0) ? 17'd1 : {1'b0, dt_q};
					t = {rem_q, dnum_q[48]};
					dnum_q <= dnum_q << 1;
					if (t >= {1'b0, dv}) begin
						rem_q <= 17'(t - {1'b0, dv});
						quo_q <= {quo_q[47:0], 1'b1};
					end else begin
						rem_q <= t[16:0];
						quo_q <= {quo_q[47:0], 1'b0};
					end
				end else begin
					rate_q <= mapg_pkg::sat32(dneg_q ? -66'(quo_q) : 66'(quo_q));
					ma_q <= kp;
					mb_q <= e_q;
				end
			end
			mapg_pkg::ST_MULP: begin
				acc_q <= 66'(prod >>> 16);
				ma_q <= ki;
				mb_q <= integ_q;
			end
			mapg_pkg::ST_MULI: begin
				acc_q <= acc_q + 66'(prod >>> 16);
				ma_q <= kd;
				mb_q <= rate_q;
			end
			mapg_pkg::ST_MULD:
				acc_q <= acc_q + 66'(prod >>> 16);
			mapg_pkg::ST_OUT: begin
				axis_out <= ax_q;
				drive <= mapg_pkg::sat32(acc_q);
				last <= ax_q == mapg_pkg::LAST_AXIS;
				at_goal <= (ax_q == mapg_pkg::LAST_AXIS) && goal_now;
			end
			default: ;
		endcase
		if (state_q == mapg_pkg::ST_OUT && ax_q == 3'd2) z_keep_q <= integ_q;
		else if (state_q == mapg_pkg::ST_READ && ax_q == 3'd2) z_keep_q <= ist;
	end

	// assertions
	a_no_out_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall) else $error("input taken with result pending");
	a_last_goal: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && at_goal) |-> last) else $error("goal flag off last axis");
	a_out_once: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mapg_pkg::ST_OUT) |=> out_valid) else $error("result lost");
endmodule

/* sim/multi_axis_pid_with_goal_check_tb.sv */
// Testbench for the multi-axis PID with goal check.
// Self-checking: a behavioral PID predictor scores every drive transfer.
// Depends on mapg_pkg and multi_axis_pid_with_goal_check.
module multi_axis_pid_with_goal_check_tb;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic kind;
		logic [2:0] axis;
		logic signed [31:0] des;
		logic signed [31:0] meas;
		logic [15:0] dt;
		logic signed [31:0] gp;
		logic signed [31:0] gi;
		logic signed [31:0] gd;
	} pid_item_t;

	typedef struct {
		logic [2:0] axis;
		logic signed [31:0] drive;
		logic at_goal;
		logic last;
	} drive_res_t;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_stall;
	logic kind = 0;
	logic [2:0] axis = 0;
	logic signed [31:0] desired_value = 0, measured_value = 0;
	logic [15:0] time_step = 1;
	logic signed [31:0] gain_prop = 0, gain_integ = 0, gain_deriv = 0;
	logic out_valid;
	logic out_stall = 0;
	logic [2:0] axis_out;
	logic signed [31:0] drive;
	logic at_goal, last;
	logic cfg_we = 0;
	logic [0:0] cfg_index = mapg_pkg::REG_TOL;
	logic [30:0] cfg_data = 0;

	multi_axis_pid_with_goal_check uut (.*);

	always #5 clk = ~clk;

	// predictor state
	longint kp[6], ki[6], kd[6], integ[6], prev_err[6];
	bit goal_acc = 1;
	longint tol = 0;
	bit auto_clr = 0;

	pid_item_t pending[$];
	drive_res_t expected_drives[$];
	int errors = 0;
	bit hold_rx = 0;
	int hold_cycles = 0;

	function automatic longint fl16(longint x);
		return x >>> 16;
	endfunction

	function automatic longint sat32v(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	// update gains or compute expected drive for one accepted transfer
	function automatic void predict_pid(pid_item_t it);
		int a;
		longint d, e, dt, rate, drv, mag, lim;
		drive_res_t r;
		a = it.axis;
		if (a >= mapg_pkg::NUM_AXES) return;
		if (it.kind) begin
			kp[a] = it.gp;
			ki[a] = it.gi;
			kd[a] = it.gd;
			return;
		end
		d = longint'(it.des) - longint'(it.meas);
		e = sat32v(d);
		dt = it.dt;
		integ[a] = sat32v(integ[a] + fl16(e * dt));
		rate = sat32v(((prev_err[a] - e) * 65536) / (dt == 0 ? 1 : dt));
		drv = sat32v(fl16(kp[a] * e) + fl16(ki[a] * integ[a]) + fl16(kd[a] * rate));
		prev_err[a] = e;
		mag = d < 0 ? -d : d;
		lim = -1;
		if (a == 0 || a == 1) lim = tol + mapg_pkg::MARGIN_XY;
		else if (a == 2) lim = tol + mapg_pkg::MARGIN_Z;
		else if (a == 5) lim = tol + mapg_pkg::MARGIN_YAW;
		if (lim >= 0 && mag > lim) goal_acc = 0;
		r.axis = it.axis;
		r.drive = drv[31:0];
		r.last = (a == mapg_pkg::NUM_AXES - 1);
		r.at_goal = 0;
		if (r.last) begin
			r.at_goal = goal_acc;
			goal_acc = 1;
			if (r.at_goal && auto_clr)
				for (int i = 0; i < mapg_pkg::NUM_AXES; i++) begin
					prev_err[i] = 0;
					if (i != 2) integ[i] = 0;
				end
		end
		expected_drives.push_back(r);
	endfunction

	task automatic report(string what);
		errors++;
		$display("mismatch @%0t: %s", $time, what);
	endtask

	// driver
	int tx_gap = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) predict_pid('{kind, axis, desired_value,
				measured_value, time_step, gain_prop, gain_integ, gain_deriv});
			if (!in_valid || !in_stall) begin
				if (tx_gap > 0) begin
					tx_gap <= tx_gap - 1;
					in_valid <= 0;
				end else if (pending.size() > 0) begin
					pid_item_t it;
					it = pending.pop_front();
					kind <= it.kind;
					axis <= it.axis;
					desired_value <= it.des;
					measured_value <= it.meas;
					time_step <= it.dt;
					gain_prop <= it.gp;
					gain_integ <= it.gi;
					gain_deriv <= it.gd;
					in_valid <= 1;
					tx_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
				end else
					in_valid <= 0;
			end
		end
	end

	// monitor and receiver stall
	int rx_gap = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_drives.size() == 0)
					report("drive transfer with nothing expected");
				else begin
					drive_res_t x;
					x = expected_drives.pop_front();
					if (axis_out !== x.axis)
						report($sformatf("axis %0d want %0d", axis_out, x.axis));
					if (drive !== x.drive)
						report($sformatf("drive %0d want %0d ax %0d", drive, x.drive, x.axis));
					if (at_goal !== x.at_goal)
						report($sformatf("at_goal %0b want %0b", at_goal, x.at_goal));
					if (last !== x.last)
						report($sformatf("last %0b want %0b", last, x.last));
				end
				rx_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
			end
			if (hold_rx) begin
				hold_cycles <= hold_cycles + 1;
				out_stall <= 1;
			end else if (rx_gap > 0) begin
				rx_gap--;
				out_stall <= 1;
			end else
				out_stall <= 0;
		end
	end

	function automatic logic signed [31:0] rnd_val(int span);
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return 32'sh7fffffff;
			2: return 32'sh80000000;
			default: return $signed($urandom_range(0, 2 * span)) - span;
		endcase
	endfunction

	function automatic pid_item_t mk(logic k, int ax, logic signed [31:0] de,
		logic signed [31:0] me, logic [15:0] dt);
		pid_item_t it;
		it.kind = k;
		it.axis = 3'(ax);
		it.des = de;
		it.meas = me;
		it.dt = dt;
		it.gp = rnd_val(1 << 17);
		it.gi = rnd_val(1 << 17);
		it.gd = rnd_val(1 << 17);
		return it;
	endfunction

	task automatic write_reg(logic [0:0] idx, logic [30:0] val);
		@(posedge clk);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 0;
		if (idx == mapg_pkg::REG_TOL) tol = val;
		else auto_clr = val[0];
	endtask

	task automatic drain;
		while (pending.size() > 0 || in_valid || expected_drives.size() > 0)
			@(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	// one sweep over every axis, desired within span of measured, random content
	task automatic queue_sweep(int span);
		for (int a = 0; a < mapg_pkg::NUM_AXES; a++) begin
			logic signed [31:0] m;
			m = $urandom;
			m = m >>> 2;
			pending.push_back(mk(0, a, m + $signed($urandom_range(0, 2 * span)) - span, m,
				$urandom_range(0, 7) == 0 ? 16'($urandom_range(0, 2)) : 16'($urandom)));
		end
	endtask

	initial begin
		for (int i = 0; i < mapg_pkg::NUM_AXES; i++) begin
			kp[i] = 0; ki[i] = 0; kd[i] = 0; integ[i] = 0; prev_err[i] = 0;
		end
		repeat (6) @(posedge clk);
		arst_n <= 1;
		// directed: gains, extremes, bad axes, zero step, alternating bit patterns
		for (int a = 0; a < 8; a++) pending.push_back(mk(1, a, 0, 0, 1));
		pending.push_back(mk(0, 0, 32'sh7fffffff, 32'sh80000000, 16'hffff));
		pending.push_back(mk(0, 1, 32'sh80000000, 32'sh7fffffff, 0));
		pending.push_back(mk(0, 6, 5, 3, 1));
		pending.push_back(mk(0, 7, 5, 3, 1));
		pending.push_back(mk(0, 2, 0, 0, 1));
		pending.push_back(mk(0, 3, -1, 1, 16'h8000));
		pending.push_back(mk(0, 4, 32'h55555555, 32'haaaaaaaa, 16'h5555));
		pending.push_back(mk(0, 5, 100, 0, 16'haaaa));
		queue_sweep(9000);
		drain();
		write_reg(mapg_pkg::REG_AUTO, 1);
		write_reg(mapg_pkg::REG_TOL, 31'h7fffffff);
		queue_sweep(1 << 30);
		queue_sweep(100);
		drain();
		// long receiver hold while sender keeps offering
		hold_rx = 1;
		queue_sweep(5000);
		queue_sweep(5000);
		while (hold_cycles < 600) @(posedge clk);
		hold_rx = 0;
		drain();
		for (int ph = 0; ph < 6; ph++) begin
			write_reg(mapg_pkg::REG_TOL, ph == 5 ? 31'd0 : 31'($urandom_range(0, 20000)));
			write_reg(mapg_pkg::REG_AUTO, ph[0]);
			for (int n = 0; n < 100; ) begin
				int r;
				r = $urandom_range(0, 9);
				if (r == 0) begin
					pending.push_back(mk(1, $urandom_range(0, 7), 0, 0, 1));
					n++;
				end else if (r == 1) begin
					pending.push_back(mk(0, $urandom_range(0, 7), $urandom, $urandom,
						16'($urandom)));
					n++;
				end else begin
					queue_sweep(ph < 3 ? 12000 : 1 << 20);
					n += 6;
				end
			end
			drain();
		end
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	initial begin
		#20ms;
		$display("*** FAILED ***");
		$finish;
	end
endmodule
